### rtl/mcnm_pkg.sv
// Shared types and constants for the mecanum four-wheel PI speed drive.
package mcnm_pkg;

    localparam int WHEELS = 4;

    // Configuration register indexes
    localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [2:0] REG_OUT_LIMIT   = 3'd2;
    localparam logic [2:0] REG_PWM_PERIOD  = 3'd3;
    localparam logic [2:0] REG_TURN_FACTOR = 3'd4;

    localparam logic [9:0]  RST_PROP_GAIN   = 10'd10;
    localparam logic [9:0]  RST_INTEG_GAIN  = 10'd10;
    localparam logic [14:0] RST_OUT_LIMIT   = 15'd6900;
    localparam logic [14:0] RST_PWM_PERIOD  = 15'd7200;
    localparam logic [9:0]  RST_TURN_FACTOR = 10'd185;

    typedef logic signed [12:0] vel_t;
    typedef logic signed [15:0] enc_t;
    typedef logic signed [14:0] tgt_t;
    typedef logic [14:0]        duty_t;

    // Settings seen by every wheel lane
    typedef struct packed {
        logic [9:0]  prop_gain;
        logic [9:0]  integ_gain;
        logic [14:0] out_limit;
        logic [14:0] pwm_period;
    } lane_cfg_t;

    // Per-stage load enables of the shared pipeline
    typedef struct packed {
        logic ld_s1;
        logic ld_s2;
        logic ld_s3;
        logic ld_s4;
        logic ld_s5;
    } pipe_ctrl_t;

endpackage

### rtl/mecanum_four_wheel_pi_speed_drive.sv
// Top level: config registers, pipeline control, wheel lanes and result merge.
//
// Mecanum four-wheel PI speed drive. One beat on the input stream carries body
// velocity targets and four encoder counts; one beat on the output carries a
// PWM duty and direction per wheel. The block is a five-stage pipeline:
// mixing product, wheel bias, PI products, accumulator, and the bridge mapping
// in the output register. A new beat is taken every cycle unless back-pressure
// stalls the pipeline; the accumulator add-and-saturate of each wheel lane
// closes within its stage, which sets that rate. Each stage holds its
// beat on back-pressure while empty stages ahead of it keep filling. Configuration
// writes are meant for idle periods.
module mecanum_four_wheel_pi_speed_drive
(
    input  logic          clk,
    input  logic          rst_n,

    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // vel_x[12:0] vel_y[25:13] vel_rot[38:26] enc_a[54:39] enc_b[70:55]
    // enc_c[86:71] enc_d[102:87], bit 103 zero
    input  logic [103:0]  s_axis_tdata,

    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // duty_a[14:0] dir_a[15] duty_b[30:16] dir_b[31]
    // duty_c[46:32] dir_c[47] duty_d[62:48] dir_d[63]
    output logic [63:0]   m_axis_tdata,

    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [14:0]   cfg_data
);

    logic [9:0]   prop_gain_reg;
    logic [9:0]   integ_gain_reg;
    logic [14:0]  out_limit_reg;
    logic [14:0]  pwm_period_reg;
    logic [9:0]   turn_factor_reg;

    logic [4:0]   valid_reg;
    logic [4:0]   valid_next;
    logic [5:0]   rdy;

    mcnm_pkg::pipe_ctrl_t  ctrl;
    mcnm_pkg::lane_cfg_t   lane_cfg;
    mcnm_pkg::enc_t        enc_in  [mcnm_pkg::WHEELS];
    mcnm_pkg::enc_t        enc_s1  [mcnm_pkg::WHEELS];
    mcnm_pkg::tgt_t        target  [mcnm_pkg::WHEELS];
    mcnm_pkg::duty_t       duty    [mcnm_pkg::WHEELS];
    logic [mcnm_pkg::WHEELS-1:0] dir;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= mcnm_pkg::RST_PROP_GAIN;
            integ_gain_reg  <= mcnm_pkg::RST_INTEG_GAIN;
            out_limit_reg   <= mcnm_pkg::RST_OUT_LIMIT;
            pwm_period_reg  <= mcnm_pkg::RST_PWM_PERIOD;
            turn_factor_reg <= mcnm_pkg::RST_TURN_FACTOR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mcnm_pkg::REG_PROP_GAIN:   prop_gain_reg   <= cfg_data[9:0];
                mcnm_pkg::REG_INTEG_GAIN:  integ_gain_reg  <= cfg_data[9:0];
                mcnm_pkg::REG_OUT_LIMIT:   out_limit_reg   <= cfg_data;
                mcnm_pkg::REG_PWM_PERIOD:  pwm_period_reg  <= cfg_data;
                mcnm_pkg::REG_TURN_FACTOR: turn_factor_reg <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    // stage k can take a beat if empty or its beat moves on this cycle
    always_comb
    begin
        rdy[5] = m_axis_tready;
        for (int k = 4; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        valid_next[0] = rdy[0] ? s_axis_tvalid : valid_reg[0];
        for (int k = 1; k < 5; k++)
        begin
            valid_next[k] = rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
        ctrl.ld_s1 = s_axis_tvalid && rdy[0];
        ctrl.ld_s2 = valid_reg[0] && rdy[1];
        ctrl.ld_s3 = valid_reg[1] && rdy[2];
        ctrl.ld_s4 = valid_reg[2] && rdy[3];
        ctrl.ld_s5 = valid_reg[3] && rdy[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = valid_reg[4];

    assign lane_cfg.prop_gain  = prop_gain_reg;
    assign lane_cfg.integ_gain = integ_gain_reg;
    assign lane_cfg.out_limit  = out_limit_reg;
    assign lane_cfg.pwm_period = pwm_period_reg;

    assign enc_in[0] = s_axis_tdata[54:39];
    assign enc_in[1] = s_axis_tdata[70:55];
    assign enc_in[2] = s_axis_tdata[86:71];
    assign enc_in[3] = s_axis_tdata[102:87];

    mcnm_mix u_mix
    (
        .clk         (clk),
        .ld          (ctrl.ld_s1),
        .vel_x       (s_axis_tdata[12:0]),
        .vel_y       (s_axis_tdata[25:13]),
        .vel_rot     (s_axis_tdata[38:26]),
        .turn_factor (turn_factor_reg),
        .enc_in      (enc_in),
        .target      (target),
        .enc_out     (enc_s1)
    );

    // wheels A and D normal polarity, B and C mirrored
    for (genvar w = 0; w < mcnm_pkg::WHEELS; w++)
    begin : g_lane
        mcnm_lane
        #(
            .MIRROR ((w == 1) || (w == 2))
        )
        u_lane
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .cfg    (lane_cfg),
            .enc    (enc_s1[w]),
            .target (target[w]),
            .duty   (duty[w]),
            .dir    (dir[w])
        );
    end

    assign m_axis_tdata = {dir[3], duty[3], dir[2], duty[2],
                           dir[1], duty[1], dir[0], duty[0]};

endmodule

### rtl/mcnm_mix.sv
// Mecanum mixing front stage: rotation product and wheel targets.
module mcnm_mix
(
    input  logic                 clk,
    input  logic                 ld,
    input  mcnm_pkg::vel_t       vel_x,
    input  mcnm_pkg::vel_t       vel_y,
    input  mcnm_pkg::vel_t       vel_rot,
    input  logic [9:0]           turn_factor,
    input  mcnm_pkg::enc_t       enc_in  [mcnm_pkg::WHEELS],
    output mcnm_pkg::tgt_t       target  [mcnm_pkg::WHEELS],
    output mcnm_pkg::enc_t       enc_out [mcnm_pkg::WHEELS]
);

    mcnm_pkg::vel_t      vx_reg;
    mcnm_pkg::vel_t      vy_reg;
    logic signed [23:0]  prod_reg;
    mcnm_pkg::enc_t      enc_reg [mcnm_pkg::WHEELS];

    logic signed [23:0]  prod_next;
    logic signed [23:0]  prod_adj;
    logic signed [13:0]  rot;
    logic signed [14:0]  vx_e;
    logic signed [14:0]  vy_e;
    logic signed [14:0]  rot_e;

    assign prod_next = 24'(vel_rot) * 24'($signed({1'b0, turn_factor}));

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            vx_reg   <= vel_x;
            vy_reg   <= vel_y;
            prod_reg <= prod_next;
            for (int i = 0; i < mcnm_pkg::WHEELS; i++)
            begin
                enc_reg[i] <= enc_in[i];
            end
        end
    end

    // divide by 1024, truncating toward zero
    always_comb
    begin
        prod_adj = prod_reg + (prod_reg[23] ? 24'sd1023 : 24'sd0);
        rot      = prod_adj[23:10];
        vx_e     = 15'(vx_reg);
        vy_e     = 15'(vy_reg);
        rot_e    = 15'(rot);
    end

    assign target[0] = -vx_e + vy_e - rot_e;
    assign target[1] =  vx_e + vy_e - rot_e;
    assign target[2] = -vx_e + vy_e + rot_e;
    assign target[3] =  vx_e + vy_e + rot_e;

    always_comb
    begin
        for (int i = 0; i < mcnm_pkg::WHEELS; i++)
        begin
            enc_out[i] = enc_reg[i];
        end
    end

endmodule

### rtl/mcnm_lane.sv
// One wheel lane: incremental PI, saturation and H-bridge mapping.
module mcnm_lane
#(
    parameter bit MIRROR = 1'b0
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mcnm_pkg::pipe_ctrl_t   ctrl,
    input  mcnm_pkg::lane_cfg_t    cfg,
    input  mcnm_pkg::enc_t         enc,
    input  mcnm_pkg::tgt_t         target,
    output mcnm_pkg::duty_t        duty,
    output logic                   dir
);

    // bias_reg doubles as the previous-error state
    logic signed [17:0]  bias_reg;
    logic signed [17:0]  delta_reg;
    logic signed [29:0]  sum_reg;
    logic signed [15:0]  acc_reg;
    mcnm_pkg::duty_t     duty_reg;
    logic                dir_reg;

    logic signed [17:0]  bias_next;
    logic signed [17:0]  delta_next;
    logic signed [28:0]  p_prod;
    logic signed [28:0]  i_prod;
    logic signed [29:0]  sum_next;
    logic signed [30:0]  acc_wide;
    logic signed [30:0]  per_wide;
    logic signed [15:0]  acc_next;
    logic signed [16:0]  acc17;
    logic signed [16:0]  lim17;
    logic signed [16:0]  per17;
    logic signed [16:0]  m;
    logic signed [16:0]  duty_wide;
    mcnm_pkg::duty_t     duty_next;
    logic                dir_next;

    always_comb
    begin
        bias_next  = 18'(enc) - 18'(target);
        delta_next = bias_next - bias_reg;
    end

    always_comb
    begin
        p_prod   = 29'(delta_reg) * 29'($signed({1'b0, cfg.prop_gain}));
        i_prod   = 29'(bias_reg) * 29'($signed({1'b0, cfg.integ_gain}));
        sum_next = 30'(p_prod) + 30'(i_prod);
    end

    // accumulator loop: one add and a symmetric saturate
    always_comb
    begin
        per_wide = $signed({16'b0, cfg.pwm_period});
        acc_wide = 31'(acc_reg) + 31'(sum_reg);
        if (acc_wide > per_wide)
        begin
            acc_next = per_wide[15:0];
        end
        else if (acc_wide < -per_wide)
        begin
            acc_next = 16'(-per_wide);
        end
        else
        begin
            acc_next = acc_wide[15:0];
        end
    end

    always_comb
    begin
        acc17 = 17'(acc_reg);
        lim17 = $signed({2'b0, cfg.out_limit});
        per17 = $signed({2'b0, cfg.pwm_period});
        if (acc17 > lim17)
        begin
            m = lim17;
        end
        else if (acc17 < -lim17)
        begin
            m = -lim17;
        end
        else
        begin
            m = acc17;
        end

        if (!MIRROR)
        begin
            if (m > 17'sd0)
            begin
                duty_wide = m;
                dir_next  = 1'b0;
            end
            else
            begin
                duty_wide = per17 + m;
                dir_next  = 1'b1;
            end
        end
        else
        begin
            if (m > 17'sd0)
            begin
                duty_wide = per17 - m;
                dir_next  = 1'b1;
            end
            else
            begin
                duty_wide = -m;
                dir_next  = 1'b0;
            end
        end
        duty_next = duty_wide[14:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (ctrl.ld_s2)
            begin
                bias_reg <= bias_next;
            end
            if (ctrl.ld_s4)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_s2)
        begin
            delta_reg <= delta_next;
        end
        if (ctrl.ld_s3)
        begin
            sum_reg <= sum_next;
        end
        if (ctrl.ld_s5)
        begin
            duty_reg <= duty_next;
            dir_reg  <= dir_next;
        end
    end

    assign duty = duty_reg;
    assign dir  = dir_reg;

endmodule

### bench/mecanum_four_wheel_pi_speed_drive_test.sv
// Self-checking stream testbench for the mecanum four-wheel PI speed drive.
`timescale 1ns / 1ps

module mecanum_four_wheel_pi_speed_drive_test;

    localparam int HOLD_OFF_CYCLES = 80;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int LATENCY_PAD     = 8;

    typedef enum int {GAP_NONE, GAP_FULL, GAP_SOME} gap_style_t;
    typedef enum int {CMD_NEAR, CMD_WIDE, CMD_EDGE} cmd_kind_t;

    // One input beat, packed in the same order as s_axis_tdata
    typedef struct packed {
        mcnm_pkg::enc_t enc_d;
        mcnm_pkg::enc_t enc_c;
        mcnm_pkg::enc_t enc_b;
        mcnm_pkg::enc_t enc_a;
        mcnm_pkg::vel_t vel_rot;
        mcnm_pkg::vel_t vel_y;
        mcnm_pkg::vel_t vel_x;
    } drive_cmd_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    // vel_x vel_y vel_rot enc_a enc_b enc_c enc_d, top bit zero
    logic [103:0]  s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    // duty_a dir_a duty_b dir_b duty_c dir_c duty_d dir_d
    logic [63:0]   m_axis_tdata;
    logic          cfg_we = 1'b0;
    logic [2:0]    cfg_index = '0;
    logic [14:0]   cfg_data = '0;

    mecanum_four_wheel_pi_speed_drive u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor copy of the settings and the per-wheel loop state
    logic [9:0]         cur_prop_gain   = mcnm_pkg::RST_PROP_GAIN;
    logic [9:0]         cur_integ_gain  = mcnm_pkg::RST_INTEG_GAIN;
    logic [14:0]        cur_out_limit   = mcnm_pkg::RST_OUT_LIMIT;
    logic [14:0]        cur_pwm_period  = mcnm_pkg::RST_PWM_PERIOD;
    logic [9:0]         cur_turn_factor = mcnm_pkg::RST_TURN_FACTOR;
    logic signed [15:0] wheel_accum     [mcnm_pkg::WHEELS] = '{default: '0};
    logic signed [17:0] wheel_prev_bias [mcnm_pkg::WHEELS] = '{default: '0};

    drive_cmd_t  drive_cmd_q [$];
    logic [63:0] duty_word_q [$];

    int         cmds_issued = 0;
    int         words_checked = 0;
    int         fail_count = 0;
    int         quiet_cycles = 0;
    bit         in_taken = 1'b0;
    bit         out_taken = 1'b0;
    gap_style_t src_style = GAP_FULL;
    gap_style_t snk_style = GAP_FULL;
    int         src_wait = 0;
    int         snk_wait = 0;
    int         hold_requests = 0;
    int         hold_served = 0;
    int         hold_left = 0;

    function automatic longint clamp_to(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Mixing, PI update and bridge mapping for all four wheels; updates loop state
    function automatic logic [63:0] predict_wheel_drive(input drive_cmd_t cmd);
        longint      enc_val [mcnm_pkg::WHEELS];
        longint      tgt [mcnm_pkg::WHEELS];
        longint      vx, vy, prod, rot, bias, acc, m, duty, period, limit;
        logic        dir_bit;
        logic [63:0] word;
        vx = cmd.vel_x;
        vy = cmd.vel_y;
        enc_val[0] = cmd.enc_a;
        enc_val[1] = cmd.enc_b;
        enc_val[2] = cmd.enc_c;
        enc_val[3] = cmd.enc_d;
        prod = longint'(cmd.vel_rot) * longint'(cur_turn_factor);
        // divide truncating toward zero
        rot = (prod < 0 ? -prod : prod) / 1024;
        if (prod < 0)
            rot = -rot;
        tgt[0] = -vx + vy - rot;
        tgt[1] = vx + vy - rot;
        tgt[2] = -vx + vy + rot;
        tgt[3] = vx + vy + rot;
        period = longint'(cur_pwm_period);
        limit = longint'(cur_out_limit);
        word = '0;
        for (int w = 0; w < mcnm_pkg::WHEELS; w++)
        begin
            bias = enc_val[w] - tgt[w];
            acc = longint'(wheel_accum[w])
                + longint'(cur_prop_gain) * (bias - longint'(wheel_prev_bias[w]))
                + longint'(cur_integ_gain) * bias;
            acc = clamp_to(acc, period);
            wheel_accum[w] = acc[15:0];
            wheel_prev_bias[w] = bias[17:0];
            m = clamp_to(acc, limit);
            if (w == 0 || w == 3)
            begin
                if (m > 0)
                begin
                    duty = m;
                    dir_bit = 1'b0;
                end
                else
                begin
                    duty = period + m;
                    dir_bit = 1'b1;
                end
            end
            else
            begin
                // B and C are mirrored
                if (m > 0)
                begin
                    duty = period - m;
                    dir_bit = 1'b1;
                end
                else
                begin
                    duty = -m;
                    dir_bit = 1'b0;
                end
            end
            word[16*w +: 15] = duty[14:0];
            word[16*w + 15] = dir_bit;
        end
        return word;
    endfunction

    function automatic int draw_wait(input gap_style_t style);
        case (style)
            GAP_NONE: return 0;
            GAP_SOME: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 19)) : 0;
            default:  return int'($urandom_range(0, 19));
        endcase
    endfunction

    function automatic longint pick_edge(input int w);
        case ($urandom_range(0, 4))
            0:       return -(longint'(1) << (w - 1));
            1:       return (longint'(1) << (w - 1)) - 1;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    function automatic drive_cmd_t make_cmd(input longint vx, input longint vy,
                                            input longint vr, input longint ea,
                                            input longint eb, input longint ec,
                                            input longint ed);
        drive_cmd_t c;
        c.vel_x = mcnm_pkg::vel_t'(vx);
        c.vel_y = mcnm_pkg::vel_t'(vy);
        c.vel_rot = mcnm_pkg::vel_t'(vr);
        c.enc_a = mcnm_pkg::enc_t'(ea);
        c.enc_b = mcnm_pkg::enc_t'(eb);
        c.enc_c = mcnm_pkg::enc_t'(ec);
        c.enc_d = mcnm_pkg::enc_t'(ed);
        return c;
    endfunction

    function automatic drive_cmd_t rand_cmd(input cmd_kind_t kind);
        case (kind)
            CMD_NEAR:
                return make_cmd(longint'($urandom_range(0, 600)) - 300,
                                longint'($urandom_range(0, 600)) - 300,
                                longint'($urandom_range(0, 600)) - 300,
                                longint'($urandom_range(0, 800)) - 400,
                                longint'($urandom_range(0, 800)) - 400,
                                longint'($urandom_range(0, 800)) - 400,
                                longint'($urandom_range(0, 800)) - 400);
            CMD_EDGE:
                return make_cmd(pick_edge(13), pick_edge(13), pick_edge(13),
                                pick_edge(16), pick_edge(16), pick_edge(16),
                                pick_edge(16));
            default:
                return drive_cmd_t'(103'({$urandom, $urandom, $urandom, $urandom}));
        endcase
    endfunction

    // Source side: one item per beat, random gap after each accepted beat
    always @(negedge clk)
    begin
        logic nxt_valid;
        if (rst_n)
        begin
            nxt_valid = s_axis_tvalid && !in_taken;
            if (!nxt_valid)
            begin
                if (src_wait > 0)
                    src_wait--;
                else if (drive_cmd_q.size() > 0)
                begin
                    s_axis_tdata <= {1'b0, drive_cmd_q.pop_front()};
                    nxt_valid = 1'b1;
                    src_wait = draw_wait(src_style);
                end
            end
            s_axis_tvalid <= nxt_valid;
        end
    end

    // Sink side: random stall after each beat, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
                snk_wait = draw_wait(snk_style);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (snk_wait > 0)
            begin
                snk_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Monitor: predict on input beats, check output beats, watchdog
    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n)
        begin
            in_taken = s_axis_tvalid && s_axis_tready;
            out_taken = m_axis_tvalid && m_axis_tready;
            if (in_taken)
                duty_word_q.push_back(predict_wheel_drive(drive_cmd_t'(s_axis_tdata[102:0])));
            if (out_taken)
            begin
                words_checked++;
                if (duty_word_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, got %h",
                             $time, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = duty_word_q.pop_front();
                    for (int w = 0; w < mcnm_pkg::WHEELS; w++)
                    begin
                        if (m_axis_tdata[16*w +: 15] !== want[16*w +: 15])
                        begin
                            $display("%0t: wheel %0d duty expected %0d got %0d", $time, w,
                                     want[16*w +: 15], m_axis_tdata[16*w +: 15]);
                            fail_count++;
                        end
                        if (m_axis_tdata[16*w + 15] !== want[16*w + 15])
                        begin
                            $display("%0t: wheel %0d dir expected %0d got %0d", $time, w,
                                     want[16*w + 15], m_axis_tdata[16*w + 15]);
                            fail_count++;
                        end
                    end
                end
            end
        end
        if (in_taken || out_taken)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [14:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            mcnm_pkg::REG_PROP_GAIN:   cur_prop_gain = val[9:0];
            mcnm_pkg::REG_INTEG_GAIN:  cur_integ_gain = val[9:0];
            mcnm_pkg::REG_OUT_LIMIT:   cur_out_limit = val;
            mcnm_pkg::REG_PWM_PERIOD:  cur_pwm_period = val;
            mcnm_pkg::REG_TURN_FACTOR: cur_turn_factor = val[9:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Writes every register, plus one write to an unmapped index
    task automatic load_settings(input logic [14:0] pg, input logic [14:0] ig,
                                 input logic [14:0] ol, input logic [14:0] pp,
                                 input logic [14:0] tf);
        write_reg(mcnm_pkg::REG_PROP_GAIN, pg);
        write_reg(mcnm_pkg::REG_TURN_FACTOR + 3'($urandom_range(1, 3)), 15'($urandom));
        write_reg(mcnm_pkg::REG_INTEG_GAIN, ig);
        write_reg(mcnm_pkg::REG_OUT_LIMIT, ol);
        write_reg(mcnm_pkg::REG_PWM_PERIOD, pp);
        write_reg(mcnm_pkg::REG_TURN_FACTOR, tf);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_cmd(input drive_cmd_t c);
        drive_cmd_q.push_back(c);
        cmds_issued++;
    endtask

    task automatic queue_random(input int n);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            queue_cmd(rand_cmd(r < 60 ? CMD_NEAR : (r < 85 ? CMD_WIDE : CMD_EDGE)));
        end
    endtask

    task automatic wait_drained();
        while (words_checked < cmds_issued)
            @(negedge clk);
        repeat (LATENCY_PAD) @(negedge clk);
    endtask

    // Gains usually small so the loops settle, sometimes anywhere in range
    function automatic logic [14:0] rand_gain();
        logic [14:0] g;
        g = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 1023))
                                        : 15'($urandom_range(0, 40));
        // stray bits above the register width
        if ($urandom_range(0, 4) == 0)
            g[14:10] = 5'($urandom);
        return g;
    endfunction

    initial
    begin
        logic [14:0] pp, ol;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: corners, truncation of negative rotation, saturation
        src_style = GAP_SOME;
        snk_style = GAP_SOME;
        queue_cmd(make_cmd(0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(4095, 4095, 4095, 32767, 32767, 32767, 32767));
        queue_cmd(make_cmd(-4096, -4096, -4096, -32768, -32768, -32768, -32768));
        queue_cmd(make_cmd(0, 0, -7, 0, 0, 0, 0));
        queue_cmd(make_cmd(0, 0, 7, 0, 0, 0, 0));
        queue_cmd(make_cmd(0, 0, -1, 0, 0, 0, 0));
        repeat (3) queue_cmd(make_cmd(0, 0, 0, 32767, -32768, 32767, -32768));
        repeat (3) queue_cmd(make_cmd(0, 0, 0, -32768, 32767, -32768, 32767));
        // encoder equal to wheel target: zero bias
        repeat (2) queue_cmd(make_cmd(10, 20, 0, 10, 30, 10, 30));
        queue_cmd(make_cmd(-4096, 4095, -4096, 0, 0, 0, 0));
        queue_cmd(make_cmd(4095, -4096, 4095, 0, 0, 0, 0));
        wait_drained();

        // Everything at full scale, gain written with bits above its width
        load_settings(15'h7FFF, 15'd1023, 15'd32767, 15'd32767, 15'd1023);
        src_style = GAP_FULL;
        snk_style = GAP_FULL;
        queue_cmd(make_cmd(0, 0, -4096, 0, 0, 0, 0));
        queue_cmd(make_cmd(0, 0, -4095, 0, 0, 0, 0));
        queue_cmd(make_cmd(4095, 4095, 4095, 32767, 32767, 32767, 32767));
        queue_random(60);
        wait_drained();

        // Gains and limit at zero, smallest period, no rotation weight
        load_settings(15'd0, 15'd0, 15'd0, 15'd1, 15'd0);
        queue_cmd(make_cmd(0, 0, 0, 0, 0, 0, 0));
        queue_random(40);
        wait_drained();

        // Zero period: every duty collapses to zero
        load_settings(15'd1023, 15'd1023, 15'd6900, 15'd0, 15'd185);
        queue_cmd(make_cmd(0, 0, 0, 0, 0, 0, 0));
        queue_random(30);
        wait_drained();

        // Limit above the period has no effect
        load_settings(15'd25, 15'd3, 15'd32767, 15'd100, 15'd512);
        src_style = GAP_NONE;
        snk_style = GAP_NONE;
        queue_random(40);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            case ($urandom_range(0, 2))
                0:       pp = 15'($urandom_range(1, 300));
                1:       pp = 15'($urandom_range(1, 32767));
                default: pp = mcnm_pkg::RST_PWM_PERIOD;
            endcase
            ol = ($urandom_range(0, 1) == 0) ? 15'($urandom_range(0, 32767))
                                             : 15'($urandom_range(0, int'(pp)));
            load_settings(rand_gain(), rand_gain(), ol, pp, rand_gain());
            src_style = gap_style_t'($urandom_range(0, 2));
            snk_style = gap_style_t'($urandom_range(0, 2));
            if (p == 3)
            begin
                // sink holds off while the source streams back to back
                src_style = GAP_NONE;
                snk_style = GAP_NONE;
                hold_requests++;
            end
            queue_random(95);
            wait_drained();
        end

        repeat (LATENCY_PAD) @(posedge clk);
        if (duty_word_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, duty_word_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
